>>> rtl/rfis_pkg.sv
// ============================================================================
// rfis_pkg : shared constants for the rotation filtered imbalance signal
// Register indexes, rotation side codes and fixed field widths.
// ============================================================================
`default_nettype none

package rfis_pkg;

    // Fixed field widths
    localparam int VOL_WIDTH     = 32;
    localparam int TICKS_WIDTH   = 9;
    localparam int DENSITY_WIDTH = 56;
    localparam int CFG_WIDTH     = 56;
    localparam int CFG_IDX_WIDTH = 1;
    localparam int FRAC_BITS     = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_ROT_TICKS = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_DENSITY   = 1'b1;

    // Rotation side codes
    typedef logic [1:0] side_t;
    localparam side_t SIDE_NONE = 2'b00;
    localparam side_t SIDE_UP   = 2'b01;
    localparam side_t SIDE_DOWN = 2'b11;

endpackage

`default_nettype wire

>>> rtl/rotation_filtered_imbalance_signal.sv
// ============================================================================
// rotation_filtered_imbalance_signal : gap imbalance signal with rotation filter
// Tracks a volume rotation over closed bars and gates buy/sell gap signals
// on rotation side, split volume and density (bit-serial divider).
// ============================================================================
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | bar_open..bar_close, volumes, bar_closed
//  out      | out_valid / out_ready| signals, markers, rotation delta/density
//  cfg      | cfg_write            | cfg_index, cfg_data (no read-back)
//
//  One item at a time. A closed bar with the filter running steps through
//  S_CAND, S_ACC, S_FLIP (skipped when it opens the first rotation), S_RANGE,
//  S_DIV when the range is positive (the restoring divider producing one
//  density bit per cycle), S_SAT and S_OUT; the next item can be accepted
//  once the sequencer is back in S_IDLE. Other items go from S_CAND to S_OUT.
//  A finished result sits in the output register while the next item is
//  accepted; a stalled output holds only the final step.
//  Reset clears all rotation state, history and registers; no clearing pass.
//
`default_nettype none

module rotation_filtered_imbalance_signal #(
    parameter int ACCUM_WIDTH = 48,
    parameter int PRICE_WIDTH = 32
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    // input channel
    input  wire logic                                     in_valid,
    output logic                                          in_ready,
    input  wire logic signed [PRICE_WIDTH-1:0]            bar_open,
    input  wire logic signed [PRICE_WIDTH-1:0]            bar_high,
    input  wire logic signed [PRICE_WIDTH-1:0]            bar_low,
    input  wire logic signed [PRICE_WIDTH-1:0]            bar_close,
    input  wire logic [rfis_pkg::VOL_WIDTH-1:0]           ask_volume,
    input  wire logic [rfis_pkg::VOL_WIDTH-1:0]           bid_volume,
    input  wire logic [rfis_pkg::VOL_WIDTH-1:0]           total_volume,
    input  wire logic                                     bar_closed,
    // output channel
    output logic                                          out_valid,
    input  wire logic                                     out_ready,
    output logic                                          buy_signal,
    output logic                                          sell_signal,
    output logic signed [PRICE_WIDTH:0]                   buy_marker,
    output logic signed [PRICE_WIDTH:0]                   sell_marker,
    output logic signed [ACCUM_WIDTH-1:0]                 rotation_delta,
    output logic [rfis_pkg::DENSITY_WIDTH-1:0]            rotation_density,
    // configuration port
    input  wire logic                                     cfg_write,
    input  wire logic [rfis_pkg::CFG_IDX_WIDTH-1:0]       cfg_index,
    input  wire logic [rfis_pkg::CFG_WIDTH-1:0]           cfg_data
);

    localparam int A  = ACCUM_WIDTH;
    localparam int P  = PRICE_WIDTH;
    localparam int DW = rfis_pkg::DENSITY_WIDTH;
    localparam int QW = ACCUM_WIDTH + rfis_pkg::FRAC_BITS;
    localparam int QX = (QW > DW) ? QW : DW;
    localparam int CNT_W = $clog2(QW);

    typedef enum logic [2:0] {
        S_IDLE, S_CAND, S_ACC, S_FLIP, S_RANGE, S_DIV, S_SAT, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [rfis_pkg::TICKS_WIDTH-1:0] min_ticks_reg;
    logic [DW-1:0]                    min_density_reg;

    // latched item
    logic signed [P-1:0]               open_reg, high_reg, low_reg, close_reg;
    logic [rfis_pkg::VOL_WIDTH-1:0]    ask_reg, bid_reg, vol_reg;
    logic                              closed_reg;

    // history and rotation state
    logic signed [P-1:0] prev_open_reg, prev_close_reg;
    logic [1:0]          closed_cnt_reg;
    rfis_pkg::side_t     side_reg;
    logic signed [P-1:0] rot_high_reg, rot_low_reg;
    logic signed [A-1:0] delta_sum_reg;
    logic [A-1:0]        vol_sum_reg;
    logic                split_reg;

    // per-item flags
    logic filt_reg, buy_cand_reg, sell_cand_reg;

    // divider
    logic [QW-1:0]    dvd_reg;
    logic [P-1:0]     rem_reg;
    logic [P-1:0]     div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    density_reg;

    // output register
    logic                  out_valid_reg;
    logic                  buy_reg, sell_reg;
    logic signed [P:0]     buy_marker_reg, sell_marker_reg;
    logic signed [A-1:0]   rot_delta_reg;
    logic [DW-1:0]         rot_density_reg;

    // bar delta and split flag
    logic signed [32:0] bar_delta;
    logic               bar_split;
    assign bar_delta = $signed({1'b0, ask_reg}) - $signed({1'b0, bid_reg});
    assign bar_split = (ask_reg | bid_reg) != '0;

    // saturating accumulators
    logic signed [A:0]   delta_wide;
    logic signed [A-1:0] delta_sum_next;
    logic [A:0]          vol_wide;
    logic [A-1:0]        vol_sum_next;
    assign delta_wide = (A+1)'(delta_sum_reg) + (A+1)'(bar_delta);
    always_comb
    begin
        if (delta_wide[A] != delta_wide[A-1])
            delta_sum_next = delta_wide[A] ? {1'b1, {(A-1){1'b0}}} : {1'b0, {(A-1){1'b1}}};
        else
            delta_sum_next = delta_wide[A-1:0];
    end
    assign vol_wide     = {1'b0, vol_sum_reg} + (A+1)'(vol_reg);
    assign vol_sum_next = vol_wide[A] ? {A{1'b1}} : vol_wide[A-1:0];

    // flip distance: one subtract with muxed operands
    logic signed [P:0] flip_a, flip_b, flip_diff, ticks_ext;
    logic              flip_hit;
    assign flip_a    = (side_reg == rfis_pkg::SIDE_UP) ? (P+1)'(rot_high_reg) : (P+1)'(close_reg);
    assign flip_b    = (side_reg == rfis_pkg::SIDE_UP) ? (P+1)'(close_reg) : (P+1)'(rot_low_reg);
    assign flip_diff = flip_a - flip_b;
    assign ticks_ext = $signed((P+1)'(min_ticks_reg));
    assign flip_hit  = flip_diff >= ticks_ext;

    // rotation range
    logic signed [P:0] range_val;
    logic              range_pos;
    assign range_val = (P+1)'(rot_high_reg) - (P+1)'(rot_low_reg);
    assign range_pos = !range_val[P] && (range_val != '0);

    // restoring divider step
    logic [P:0] trial, trial_sub;
    logic       trial_ge;
    assign trial     = {rem_reg, dvd_reg[QW-1]};
    assign trial_ge  = trial >= {1'b0, div_reg};
    assign trial_sub = trial - {1'b0, div_reg};

    // density saturation
    logic [QX-1:0] q_ext;
    logic          q_over;
    assign q_ext  = QX'(dvd_reg);
    assign q_over = (q_ext >> DW) != '0;

    // filter pass
    logic dens_ok, ok_long, ok_short, buy_now, sell_now;
    assign dens_ok  = density_reg >= min_density_reg;
    assign ok_long  = !filt_reg || (split_reg && side_reg == rfis_pkg::SIDE_UP && dens_ok);
    assign ok_short = !filt_reg || (split_reg && side_reg != rfis_pkg::SIDE_UP && dens_ok);
    assign buy_now  = buy_cand_reg && ok_long;
    assign sell_now = sell_cand_reg && ok_short;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_ticks_reg   <= '0;
            min_density_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rfis_pkg::REG_MIN_ROT_TICKS: min_ticks_reg   <= cfg_data[rfis_pkg::TICKS_WIDTH-1:0];
                rfis_pkg::REG_MIN_DENSITY:   min_density_reg <= cfg_data[DW-1:0];
            endcase
        end
    end

    // sequencer, datapath and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            open_reg        <= '0;
            high_reg        <= '0;
            low_reg         <= '0;
            close_reg       <= '0;
            ask_reg         <= '0;
            bid_reg         <= '0;
            vol_reg         <= '0;
            closed_reg      <= 1'b0;
            prev_open_reg   <= '0;
            prev_close_reg  <= '0;
            closed_cnt_reg  <= '0;
            side_reg        <= rfis_pkg::SIDE_NONE;
            rot_high_reg    <= '0;
            rot_low_reg     <= '0;
            delta_sum_reg   <= '0;
            vol_sum_reg     <= '0;
            split_reg       <= 1'b0;
            filt_reg        <= 1'b0;
            buy_cand_reg    <= 1'b0;
            sell_cand_reg   <= 1'b0;
            dvd_reg         <= '0;
            rem_reg         <= '0;
            div_reg         <= '0;
            cnt_reg         <= '0;
            density_reg     <= '0;
            out_valid_reg   <= 1'b0;
            buy_reg         <= 1'b0;
            sell_reg        <= 1'b0;
            buy_marker_reg  <= '0;
            sell_marker_reg <= '0;
            rot_delta_reg   <= '0;
            rot_density_reg <= '0;
        end
        else
        begin
            // result taken downstream; S_OUT reloads it itself
            if (out_valid_reg && out_ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        open_reg   <= bar_open;
                        high_reg   <= bar_high;
                        low_reg    <= bar_low;
                        close_reg  <= bar_close;
                        ask_reg    <= ask_volume;
                        bid_reg    <= bid_volume;
                        vol_reg    <= total_volume;
                        closed_reg <= bar_closed;
                        state_reg  <= S_CAND;
                    end
                end

                // gap candidates against the old history, then update history
                S_CAND:
                begin
                    filt_reg      <= closed_reg && closed_cnt_reg[1] && (min_ticks_reg != '0);
                    buy_cand_reg  <= closed_reg && closed_cnt_reg[1] &&
                                     close_reg > open_reg && prev_close_reg > prev_open_reg &&
                                     open_reg > prev_close_reg;
                    sell_cand_reg <= closed_reg && closed_cnt_reg[1] &&
                                     close_reg < open_reg && prev_close_reg < prev_open_reg &&
                                     open_reg < prev_close_reg;
                    if (closed_reg)
                    begin
                        prev_open_reg  <= open_reg;
                        prev_close_reg <= close_reg;
                        if (!closed_cnt_reg[1])
                            closed_cnt_reg <= closed_cnt_reg + 2'd1;
                    end
                    if (closed_reg && closed_cnt_reg[1] && (min_ticks_reg != '0))
                        state_reg <= S_ACC;
                    else
                        state_reg <= S_OUT;
                end

                // accumulate, or start the first rotation
                S_ACC:
                begin
                    if (side_reg == rfis_pkg::SIDE_NONE)
                    begin
                        side_reg      <= (ask_reg >= bid_reg) ? rfis_pkg::SIDE_UP
                                                              : rfis_pkg::SIDE_DOWN;
                        rot_high_reg  <= high_reg;
                        rot_low_reg   <= low_reg;
                        delta_sum_reg <= A'(bar_delta);
                        vol_sum_reg   <= A'(vol_reg);
                        split_reg     <= bar_split;
                        state_reg     <= S_RANGE;
                    end
                    else
                    begin
                        delta_sum_reg <= delta_sum_next;
                        vol_sum_reg   <= vol_sum_next;
                        split_reg     <= split_reg || bar_split;
                        if (high_reg > rot_high_reg)
                            rot_high_reg <= high_reg;
                        if (low_reg < rot_low_reg)
                            rot_low_reg <= low_reg;
                        state_reg <= S_FLIP;
                    end
                end

                // side flip restarts the rotation at this bar
                S_FLIP:
                begin
                    if (flip_hit)
                    begin
                        side_reg      <= (side_reg == rfis_pkg::SIDE_UP) ? rfis_pkg::SIDE_DOWN
                                                                         : rfis_pkg::SIDE_UP;
                        rot_high_reg  <= close_reg;
                        rot_low_reg   <= close_reg;
                        delta_sum_reg <= A'(bar_delta);
                        vol_sum_reg   <= A'(vol_reg);
                        split_reg     <= bar_split;
                    end
                    state_reg <= S_RANGE;
                end

                // load divider; zero or negative range passes volume through
                S_RANGE:
                begin
                    dvd_reg <= {vol_sum_reg, {rfis_pkg::FRAC_BITS{1'b0}}};
                    rem_reg <= '0;
                    div_reg <= range_val[P-1:0];
                    cnt_reg <= CNT_W'(QW - 1);
                    state_reg <= range_pos ? S_DIV : S_SAT;
                end

                // one quotient bit per cycle
                S_DIV:
                begin
                    rem_reg <= trial_ge ? trial_sub[P-1:0] : trial[P-1:0];
                    dvd_reg <= {dvd_reg[QW-2:0], trial_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= S_SAT;
                end

                S_SAT:
                begin
                    density_reg <= q_over ? {DW{1'b1}} : q_ext[DW-1:0];
                    state_reg   <= S_OUT;
                end

                // load the output register once it is free
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        buy_reg         <= buy_now;
                        sell_reg        <= sell_now;
                        buy_marker_reg  <= buy_now ? (P+1)'(low_reg) - (P+1)'(2) : '0;
                        sell_marker_reg <= sell_now ? (P+1)'(high_reg) + (P+1)'(2) : '0;
                        rot_delta_reg   <= filt_reg ? delta_sum_reg : '0;
                        rot_density_reg <= filt_reg ? density_reg : '0;
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready         = (state_reg == S_IDLE);
    assign out_valid        = out_valid_reg;
    assign buy_signal       = buy_reg;
    assign sell_signal      = sell_reg;
    assign buy_marker       = buy_marker_reg;
    assign sell_marker      = sell_marker_reg;
    assign rotation_delta   = rot_delta_reg;
    assign rotation_density = rot_density_reg;

    // checks
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while one is in flight");

    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(buy_signal && sell_signal))
        else $error("buy and sell on the same item");

    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && cnt_reg == '0 |=> state_reg == S_SAT)
        else $error("divider did not finish after its last bit");

    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !buy_signal |-> buy_marker == '0)
        else $error("buy marker set without buy signal");

endmodule

`default_nettype wire
